// ----- rtl/bmi_pkg.sv -----
// Shared constants for the binary modular inverse core.
package bmi_pkg;

    localparam int NUM_WORDS_DEF = 6;
    localparam int WORD_BITS     = 32;
    localparam int CFG_BITS      = 64;
    localparam int CFG_IDX_BITS  = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_MOD_HIGH = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_MOD_MID  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_MOD_LOW  = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_OP  = 2'd1;
    localparam logic [1:0] ST_BAD_MOD  = 2'd2;
    localparam logic [1:0] ST_NOT_COPR = 2'd3;

endpackage

// ----- rtl/bmi_front.sv -----
// Front end: gathers operand words and hands complete operands to the queue.
module bmi_front #(
    parameter int NUM_WORDS = bmi_pkg::NUM_WORDS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [bmi_pkg::WORD_BITS-1:0]  i_operand_word,
    input  logic                           i_word_last,
    input  logic                           i_full,
    output logic                           o_push,
    output logic [32*NUM_WORDS-1:0]        o_push_data
);
    localparam int W = 32 * NUM_WORDS;

    logic [W-1:0] r_acc;
    logic [W-1:0] n_acc;
    logic         accept;

    assign o_in_ready = !i_full;
    assign accept     = i_in_valid && !i_full;

    // New word enters at the low end; oldest word drops off the top
    assign o_push_data = {r_acc[W-bmi_pkg::WORD_BITS-1:0], i_operand_word};
    assign o_push      = accept && i_word_last;

    always_comb begin
        n_acc = r_acc;
        if (accept) begin
            n_acc = i_word_last ? '0 : o_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else begin
            r_acc <= n_acc;
        end
    end

endmodule

// ----- rtl/bmi_queue.sv -----
// Two-entry queue of loaded operands between front end and engine.
module bmi_queue #(
    parameter int WIDTH = 32 * bmi_pkg::NUM_WORDS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop)  r_rp <= !r_rp;
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- rtl/bmi_engine.sv -----
// Back end: binary extended Euclidean iteration and result serialiser.
module bmi_engine #(
    parameter int NUM_WORDS = bmi_pkg::NUM_WORDS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_q_valid,
    output logic                           o_q_pop,
    input  logic [32*NUM_WORDS-1:0]        i_q_data,
    input  logic [32*NUM_WORDS-1:0]        i_modulus,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [bmi_pkg::WORD_BITS-1:0]  o_result_word,
    output logic                           o_result_last,
    output logic [1:0]                     o_status
);
    localparam int W  = 32 * NUM_WORDS;
    localparam int CW = $clog2(NUM_WORDS);
    localparam logic [CW-1:0] LAST_IDX = CW'(NUM_WORDS - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_STEP = 3'd1;
    localparam logic [2:0] S_SUB  = 3'd2;
    localparam logic [2:0] S_FIX  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]    r_state;
    logic [W-1:0]  r_u, r_v, r_a, r_c;
    logic          r_ugt, r_bor;
    logic [1:0]    r_status;
    logic [CW-1:0] r_cnt;

    logic [W-1:0]  hsel, hres, vbig, vsmall, vdiff, cbig, csmall, ftgt, fsum;
    logic [W:0]    hsum, cdiff;
    logic          out_acc;

    // Halving modulo p: (x + p) / 2 for odd x, shared by A and C
    assign hsel = r_u[0] ? r_c : r_a;
    assign hsum = {1'b0, hsel} + (hsel[0] ? {1'b0, i_modulus} : '0);
    assign hres = hsum[W:1];

    // Larger minus smaller, with the matching coefficient difference
    assign vbig   = r_ugt ? r_u : r_v;
    assign vsmall = r_ugt ? r_v : r_u;
    assign vdiff  = vbig - vsmall;
    assign cbig   = r_ugt ? r_a : r_c;
    assign csmall = r_ugt ? r_c : r_a;
    assign cdiff  = {1'b0, cbig} - {1'b0, csmall};

    // Correction after a borrow: add p back
    assign ftgt = r_ugt ? r_a : r_c;
    assign fsum = ftgt + i_modulus;

    assign o_q_pop       = (r_state == S_IDLE) && i_q_valid;
    assign o_out_valid   = (r_state == S_OUT);
    assign o_result_word = r_c[W-1 -: bmi_pkg::WORD_BITS];
    assign o_result_last = (r_cnt == LAST_IDX);
    assign o_status      = r_status;
    assign out_acc       = o_out_valid && i_out_ready;

    // Datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_u <= i_q_data;
                r_v <= i_modulus;
                r_a <= W'(1);
                r_c <= '0;
            end
            S_STEP: begin
                if (!r_u[0]) begin
                    r_u <= r_u >> 1;
                    r_a <= hres;
                end else if (!r_v[0]) begin
                    r_v <= r_v >> 1;
                    r_c <= hres;
                end else if (r_u == r_v) begin
                    if (r_u != W'(1)) r_c <= '0;
                end else begin
                    r_ugt <= (r_u > r_v);
                end
            end
            S_SUB: begin
                r_bor <= cdiff[W];
                if (r_ugt) begin
                    r_u <= vdiff;
                    r_a <= cdiff[W-1:0];
                end else begin
                    r_v <= vdiff;
                    r_c <= cdiff[W-1:0];
                end
            end
            S_FIX: begin
                if (r_bor) begin
                    if (r_ugt) r_a <= fsum;
                    else       r_c <= fsum;
                end
            end
            S_OUT: begin
                if (out_acc) r_c <= r_c << bmi_pkg::WORD_BITS;
            end
            default: begin
                r_c <= r_c;
            end
        endcase
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= bmi_pkg::ST_OK;
            r_cnt    <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_cnt <= '0;
                    if (i_q_valid) begin
                        if (!i_modulus[0]) begin
                            r_status <= bmi_pkg::ST_BAD_MOD;
                            r_state  <= S_OUT;
                        end else if (i_q_data == '0) begin
                            r_status <= bmi_pkg::ST_ZERO_OP;
                            r_state  <= S_OUT;
                        end else begin
                            r_status <= bmi_pkg::ST_OK;
                            r_state  <= S_STEP;
                        end
                    end
                end
                S_STEP: begin
                    if (r_u[0] && r_v[0]) begin
                        if (r_u == r_v) begin
                            if (r_u != W'(1)) r_status <= bmi_pkg::ST_NOT_COPR;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_SUB;
                        end
                    end
                end
                S_SUB: r_state <= S_FIX;
                S_FIX: r_state <= S_STEP;
                S_OUT: begin
                    if (out_acc) begin
                        r_cnt <= r_cnt + CW'(1);
                        if (r_cnt == LAST_IDX) r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- rtl/binary_modular_inverse_core.sv -----
// Binary modular inverse core: top level with modulus registers.
//
// Operand requests arrive on the input channel as NUM_WORDS 32-bit words,
// most significant first; word_last closes the operand. The front end
// shifts words into an accumulator and places each complete operand in a
// two-entry queue, so a further operand can be loaded while the engine
// works. The engine runs one binary extended Euclidean step at a time:
// a halving step is a pass through the step state, a subtract step runs
// compare, subtract and modular correction, and a load starts each run,
// which ends when the step state finds u equal to v. Each subtraction
// is followed by a halving, with at most 2*W halvings for W = 32*NUM_WORDS
// bits; a zero operand or an even modulus goes to output straight after
// the load. The result leaves as NUM_WORDS word requests, one per cycle
// while the receiver is ready, with result_last on the final word and the
// status on every word. A stalled receiver holds the engine in its output
// phase; the queue and loader keep accepting until both queue entries are
// full. The user must write the modulus over the configuration channel
// only while the core is idle; the core itself does not enforce this.
// Reset clears the modulus registers, the loader, the queue and the engine.
module binary_modular_inverse_core #(
    parameter int NUM_WORDS = bmi_pkg::NUM_WORDS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [bmi_pkg::WORD_BITS-1:0]     i_operand_word,
    input  logic                              i_word_last,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [bmi_pkg::WORD_BITS-1:0]     o_result_word,
    output logic                              o_result_last,
    output logic [1:0]                        o_status,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bmi_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [bmi_pkg::CFG_BITS-1:0]      i_cfg_data
);
    localparam int W = 32 * NUM_WORDS;

    logic [bmi_pkg::CFG_BITS-1:0] r_mod_high, r_mod_mid, r_mod_low;
    logic [3*bmi_pkg::CFG_BITS-1:0] mod_full;
    logic [W-1:0] modulus;
    logic         q_full, q_push, q_pop, q_valid;
    logic [W-1:0] push_data, q_data;

    assign o_cfg_ready = 1'b1;
    assign mod_full    = {r_mod_high, r_mod_mid, r_mod_low};
    assign modulus     = mod_full[W-1:0];

    // Modulus registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod_high <= '0;
            r_mod_mid  <= '0;
            r_mod_low  <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                bmi_pkg::REG_MOD_HIGH: r_mod_high <= i_cfg_data;
                bmi_pkg::REG_MOD_MID:  r_mod_mid  <= i_cfg_data;
                bmi_pkg::REG_MOD_LOW:  r_mod_low  <= i_cfg_data;
                default:               r_mod_low  <= r_mod_low;
            endcase
        end
    end

    bmi_front #(.NUM_WORDS(NUM_WORDS)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_operand_word (i_operand_word),
        .i_word_last    (i_word_last),
        .i_full         (q_full),
        .o_push         (q_push),
        .o_push_data    (push_data)
    );

    bmi_queue #(.WIDTH(W)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (push_data),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    bmi_engine #(.NUM_WORDS(NUM_WORDS)) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .o_q_pop       (q_pop),
        .i_q_data      (q_data),
        .i_modulus     (modulus),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_result_word (o_result_word),
        .o_result_last (o_result_last),
        .o_status      (o_status)
    );

endmodule

// ----- tb/binary_modular_inverse_core_chk.sv -----
// Checker for the binary modular inverse core: predicts and compares result words.
module binary_modular_inverse_core_chk (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_ready,
    input  logic [bmi_pkg::WORD_BITS-1:0]    i_operand_word,
    input  logic                             i_word_last,
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    input  logic [bmi_pkg::WORD_BITS-1:0]    i_result_word,
    input  logic                             i_result_last,
    input  logic [1:0]                       i_status,
    input  logic                             i_cfg_valid,
    input  logic                             i_cfg_ready,
    input  logic [bmi_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [bmi_pkg::CFG_BITS-1:0]     i_cfg_data,
    output int                               o_errors,
    output int                               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int W = 32 * bmi_pkg::NUM_WORDS_DEF;

    typedef struct packed {
        logic [bmi_pkg::WORD_BITS-1:0] word;
        logic                          last;
        logic [1:0]                    status;
    } t_inv_word;

    logic [bmi_pkg::CFG_BITS-1:0] mod_high, mod_mid, mod_low;
    logic [W-1:0]                 operand_acc;
    t_inv_word                    inverse_q[$];

    // Binary extended Euclid, all values kept at W bits with one carry bit
    function automatic void compute_inverse(input logic [W-1:0] op, input logic [W-1:0] p,
                                            output logic [1:0] st,
                                            output logic [W-1:0] inv);
        logic [W-1:0] u, v, a, c;
        logic [W:0]   s;
        u = op; v = p; a = W'(1); c = '0; inv = '0; st = bmi_pkg::ST_OK;
        if (!p[0]) begin
            st = bmi_pkg::ST_BAD_MOD;
            return;
        end
        if (op == '0) begin
            st = bmi_pkg::ST_ZERO_OP;
            return;
        end
        forever begin
            while (!u[0]) begin
                u = u >> 1;
                s = a[0] ? {1'b0, a} + {1'b0, p} : {1'b0, a};
                a = s[W:1];
            end
            while (!v[0]) begin
                v = v >> 1;
                s = c[0] ? {1'b0, c} + {1'b0, p} : {1'b0, c};
                c = s[W:1];
            end
            if (u == v) break;
            if (u > v) begin
                u = u - v;
                a = (a >= c) ? a - c : a - c + p;
            end else begin
                v = v - u;
                c = (c >= a) ? c - a : c - a + p;
            end
        end
        if (u != W'(1)) st = bmi_pkg::ST_NOT_COPR;
        else inv = c;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch: %s got %h expected %h at %0t", what, got, want, $realtime);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        logic [W-1:0]   p, inv, nxt;
        logic [1:0]     st;
        t_inv_word      got, want;
        if (!i_rst_n) begin
            mod_high <= '0; mod_mid <= '0; mod_low <= '0;
            operand_acc <= '0;
            o_errors = 0;
            inverse_q.delete();
        end else begin
            // register writes
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    bmi_pkg::REG_MOD_HIGH: mod_high <= i_cfg_data;
                    bmi_pkg::REG_MOD_MID:  mod_mid  <= i_cfg_data;
                    bmi_pkg::REG_MOD_LOW:  mod_low  <= i_cfg_data;
                    default: ;
                endcase
            end
            // operand request
            if (i_in_valid && i_in_ready) begin
                nxt = {operand_acc[W-33:0], i_operand_word};
                if (i_word_last) begin
                    p = {mod_high, mod_mid, mod_low};
                    compute_inverse(nxt, p, st, inv);
                    for (int k = 0; k < bmi_pkg::NUM_WORDS_DEF; k++)
                        inverse_q.push_back('{inv[W-1-32*k -: 32],
                                              k == bmi_pkg::NUM_WORDS_DEF - 1, st});
                    operand_acc <= '0;
                end else begin
                    operand_acc <= nxt;
                end
            end
            // result request
            if (i_out_valid && i_out_ready) begin
                got = '{i_result_word, i_result_last, i_status};
                if (inverse_q.size() == 0) begin
                    report_mismatch("unexpected word", got.word, 0);
                end else begin
                    want = inverse_q.pop_front();
                    if (got.word != want.word)
                        report_mismatch("result_word", got.word, want.word);
                    if (got.last != want.last)
                        report_mismatch("result_last", got.last, want.last);
                    if (got.status != want.status)
                        report_mismatch("status", got.status, want.status);
                end
            end
        end
        o_pending = inverse_q.size();
    end
endmodule

// ----- tb/binary_modular_inverse_core_tb.sv -----
// Testbench top for the binary modular inverse core: stimulus and verdict.
module binary_modular_inverse_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  W         = 32 * bmi_pkg::NUM_WORDS_DEF;
    localparam int  CYCLE_CAP = 2000000;

    logic                             i_clk, i_rst_n;
    logic                             i_in_valid, o_in_ready, i_word_last;
    logic [bmi_pkg::WORD_BITS-1:0]    i_operand_word;
    logic                             o_out_valid, i_out_ready, o_result_last;
    logic [bmi_pkg::WORD_BITS-1:0]    o_result_word;
    logic [1:0]                       o_status;
    logic                             i_cfg_valid, o_cfg_ready;
    logic [bmi_pkg::CFG_IDX_BITS-1:0] i_cfg_index;
    logic [bmi_pkg::CFG_BITS-1:0]     i_cfg_data;
    int                               errors, pending;
    int                               send_idle, recv_stall;
    int                               hold_off;
    int                               cycles;
    logic [W-1:0]                     modulus;

    binary_modular_inverse_core DUT (.*);

    binary_modular_inverse_core_chk u_chk (
        .i_clk, .i_rst_n,
        .i_in_valid, .i_in_ready(o_in_ready), .i_operand_word, .i_word_last,
        .i_out_valid(o_out_valid), .i_out_ready, .i_result_word(o_result_word),
        .i_result_last(o_result_last), .i_status(o_status),
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_CAP) begin
                $display("binary_modular_inverse_core_tb: done, errors");
                $finish;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    initial begin
        i_out_ready = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                i_out_ready <= 0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_stall);
            end
        end
    end

    // Valid stays up between back-to-back writes; set_modulus drops it
    task automatic write_reg(input logic [bmi_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [bmi_pkg::CFG_BITS-1:0] d);
        i_cfg_valid <= 1; i_cfg_index <= idx; i_cfg_data <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic set_modulus(input logic [W-1:0] p);
        modulus = p;
        write_reg(bmi_pkg::REG_MOD_HIGH, p[191:128]);
        write_reg(bmi_pkg::REG_MOD_MID,  p[127:64]);
        write_reg(bmi_pkg::REG_MOD_LOW,  p[63:0]);
        i_cfg_valid <= 0;
    endtask

    // Valid is dropped only while idling; drain drops it after the last word
    task automatic send_word(input logic [31:0] w, input logic last);
        while ($urandom_range(99) < send_idle) begin
            i_in_valid <= 0;
            @(posedge i_clk);
        end
        i_in_valid <= 1; i_operand_word <= w; i_word_last <= last;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic send_operand(input logic [W-1:0] op, input int nwords);
        for (int k = nwords - 1; k >= 0; k--)
            send_word(k < bmi_pkg::NUM_WORDS_DEF ? op[32*k +: 32] : $urandom, k == 0);
    endtask

    // Idle the core before touching the modulus
    task automatic drain;
        int n;
        n = 0;
        i_in_valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        while (n < 1200) begin
            @(posedge i_clk);
            n++;
        end
    endtask

    function automatic logic [W-1:0] rand_wide;
        logic [W-1:0] r;
        for (int k = 0; k < bmi_pkg::NUM_WORDS_DEF; k++) r[32*k +: 32] = $urandom;
        return r;
    endfunction

    // Random operand: mostly full width, sometimes short or overlong or shaped
    task automatic random_operand;
        logic [W-1:0] op;
        int           nw;
        op = rand_wide();
        case ($urandom_range(9))
            0: op = op & ((192'd1 << $urandom_range(1, 191)) - 1);
            1: op = modulus * $urandom_range(0, 3);
            2: op = {W{1'b1}};
            default: ;
        endcase
        nw = bmi_pkg::NUM_WORDS_DEF;
        if ($urandom_range(9) == 0) nw = $urandom_range(1, 8);
        send_operand(op, nw);
    endtask

    initial begin
        logic [W-1:0] moduli[6];
        i_rst_n = 0; i_in_valid = 0; i_operand_word = 0; i_word_last = 0;
        i_cfg_valid = 0; i_cfg_index = bmi_pkg::REG_MOD_HIGH; i_cfg_data = 0;
        send_idle = 0; recv_stall = 0; hold_off = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: odd prime-like, even and zero moduli, edge operands
        set_modulus({W{1'b1}});
        send_operand(1, 6);
        send_operand(0, 6);
        send_operand({W{1'b1}}, 6);
        send_operand(192'd3, 6);
        send_operand(192'h8000_0000 << 160, 6);
        send_operand(192'h5, 1);
        send_operand(192'h7, 8);
        drain();
        set_modulus(192'd0);
        send_operand(192'd9, 6);
        send_operand(0, 6);
        drain();
        set_modulus({1'b1, {(W-2){1'b0}}, 1'b0});
        send_operand(192'd3, 6);
        drain();
        set_modulus(192'hffff_ffff_ffff_ffff_ffff_ffff_ffff_ffff_ffff_fffe_ffff_ffff);
        send_operand(192'd2, 6);
        send_operand(192'hffff_ffff_ffff_ffff_ffff_ffff_ffff_fffe_ffff_fffe, 6);
        send_operand(modulus, 6);
        send_operand(modulus + 1, 6);
        drain();
        set_modulus(192'd15);
        send_operand(192'd5, 6);
        send_operand(192'd7, 6);
        send_operand(192'd1, 2);
        drain();

        // Long receiver hold-off while operands keep coming
        hold_off = 3000;
        for (int k = 0; k < 6; k++) send_operand(rand_wide(), 6);
        drain();

        // Random phases across several moduli and idling mixes
        moduli[0] = {W{1'b1}};
        moduli[1] = rand_wide() | 1;
        moduli[2] = 192'd1;
        moduli[3] = 192'd3;
        moduli[4] = rand_wide() & ~192'd1;
        moduli[5] = {1'b1, {(W-2){1'b0}}, 1'b1};
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 72; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 72; end
                default: begin send_idle = 19; recv_stall = 19; end
            endcase
            set_modulus(ph < 6 ? moduli[ph] : (rand_wide() | 1));
            repeat (7) random_operand();
            drain();
        end

        if (errors == 0) begin
            $display("binary_modular_inverse_core_tb: done, clean");
        end else begin
            $display("binary_modular_inverse_core_tb: done, errors");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/bmi_pkg.sv
rtl/bmi_front.sv
rtl/bmi_queue.sv
rtl/bmi_engine.sv
rtl/binary_modular_inverse_core.sv
tb/binary_modular_inverse_core_chk.sv
tb/binary_modular_inverse_core_tb.sv
